@@ rtl/core/sempool_pkg.sv @@
// Package with the request and status codes of the semaphore pool.
`timescale 1ns / 1ps

package sempool_pkg;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] status_t;
	typedef logic signed [15:0] count_t;

	localparam opcode_t OP_NEW    = 2'd0;
	localparam opcode_t OP_WAIT   = 2'd1;
	localparam opcode_t OP_SIGNAL = 2'd2;
	localparam opcode_t OP_FREE   = 2'd3;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_BAD_ID  = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_WAITERS = 2'd3;

	localparam count_t CNT_MIN = 16'sh8000;
	localparam count_t CNT_MAX = 16'sh7FFF;
	localparam count_t CNT_ONE = 16'sd1;

	localparam int SEM_ID_W = 4;
	localparam int REQ_ID_W = 5;

endpackage

@@ rtl/core/sempool_alloc.sv @@
// Priority encoder that finds the lowest unused semaphore slot.
`timescale 1ns / 1ps

module sempool_alloc #(
	parameter int NUM_SEMAPHORES = 16,
	localparam int IDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1
) (
	input  logic [NUM_SEMAPHORES-1:0] used,
	output sempool_pkg::status_t      status,
	output logic [IDX_W-1:0]          idx
);
	import sempool_pkg::*;

	always_comb begin
		status = ST_FULL;
		idx = '0;
		// Scan from the top so the lowest free slot wins.
		for (int i = NUM_SEMAPHORES - 1; i >= 0; i--) begin
			if (!used[i]) begin
				status = ST_OK;
				idx = IDX_W'(i);
			end
		end
	end

endmodule

@@ rtl/core/semaphore_pool_with_wait_queues.sv @@
// Top level of the counting semaphore pool with per-slot FIFO wait queues.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_ready   opcode, sem_id, init_value, requester_id
//   out      from block out_valid / out_ready status, new_sem_id, block_requester,
//                                             wake_valid, wake_id
//
// One request per cycle is sustained while out_ready is high; each request waits in the
// input register until the result register can take it, and its result appears from there.
// All slot state is read and written in the single pass between the two registers.
// Reset clears every used bit, queue flag and count at once; no clearing pass.
// A stalled result holds the input register, so in_ready drops only while both
// registers are full and out_ready is low.
`timescale 1ns / 1ps

module semaphore_pool_with_wait_queues #(
	parameter int NUM_SEMAPHORES = 16,
	parameter int NUM_REQUESTERS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sempool_pkg::opcode_t   opcode,
	input  logic [3:0]             sem_id,
	input  logic signed [15:0]     init_value,
	input  logic [4:0]             requester_id,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sempool_pkg::status_t   status,
	output logic [3:0]             new_sem_id,
	output logic                   block_requester,
	output logic                   wake_valid,
	output logic [4:0]             wake_id
);
	import sempool_pkg::*;

	localparam int SIDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int CMP_W  = ((SIDX_W > SEM_ID_W) ? SIDX_W : SEM_ID_W) + 1;
	localparam int REQ_W  = $clog2(NUM_REQUESTERS);
	localparam int WID_W  = (REQ_W > REQ_ID_W) ? REQ_W : REQ_ID_W;
	localparam int NID_W  = (SIDX_W > SEM_ID_W) ? SIDX_W : SEM_ID_W;
	localparam int REQ_IDS = 1 << REQ_ID_W;

	// Input register.
	logic              valid_s1;
	opcode_t           opcode_s1;
	logic [3:0]        sem_id_s1;
	count_t            init_value_s1;
	logic [4:0]        requester_id_s1;

	// Result register.
	logic              out_valid_q;
	status_t           status_q;
	logic [3:0]        new_sem_id_q;
	logic              block_q;
	logic              wake_valid_q;
	logic [4:0]        wake_id_q;

	// Slot state.
	logic [NUM_SEMAPHORES-1:0] used_q;
	logic [NUM_SEMAPHORES-1:0] nonempty_q;
	count_t                    count_q [NUM_SEMAPHORES];
	logic [REQ_W-1:0]          head_q [NUM_SEMAPHORES];
	logic [REQ_W-1:0]          tail_q [NUM_SEMAPHORES];
	logic [REQ_W-1:0]          next_q [NUM_REQUESTERS];

	logic              advance;
	status_t           alloc_status;
	logic [SIDX_W-1:0] alloc_idx;
	logic [CMP_W-1:0]  sid_wide;
	logic [SIDX_W-1:0] sid;
	logic              sid_ok;
	logic              ne_cur;
	count_t            cnt_cur;
	count_t            cnt_d;
	logic [REQ_W-1:0]  head_cur;
	logic [REQ_W-1:0]  tail_cur;
	logic [REQ_W-1:0]  req_map [REQ_IDS];
	logic [REQ_W-1:0]  req;
	logic [WID_W-1:0]  head_wide;
	logic [NID_W-1:0]  alloc_wide;

	status_t           st_d;
	logic [3:0]        new_id_d;
	logic              blk_d;
	logic              wake_d;
	logic [4:0]        wake_id_d;
	logic              do_new;
	logic              do_free;
	logic              do_enq;
	logic              do_deq;
	logic              cnt_we;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1       <= opcode;
			sem_id_s1       <= sem_id;
			init_value_s1   <= init_value;
			requester_id_s1 <= requester_id;
		end
	end

	// Requester ids reduced modulo the number of queue links.
	for (genvar g = 0; g < REQ_IDS; g++) begin : g_req_map
		localparam int RM = g % NUM_REQUESTERS;
		assign req_map[g] = REQ_W'(RM);
	end

	assign req = req_map[requester_id_s1];

	sempool_alloc #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES)
	) u_alloc (
		.used   (used_q),
		.status (alloc_status),
		.idx    (alloc_idx)
	);

	assign sid_wide = CMP_W'(sem_id_s1);
	assign sid      = sid_wide[SIDX_W-1:0];
	assign sid_ok   = (sid_wide < CMP_W'(NUM_SEMAPHORES)) && used_q[sid];
	assign ne_cur   = nonempty_q[sid];
	assign cnt_cur  = count_q[sid];
	assign head_cur = head_q[sid];
	assign tail_cur = tail_q[sid];
	assign head_wide  = WID_W'(head_cur);
	assign alloc_wide = NID_W'(alloc_idx);

	always_comb begin
		st_d      = ST_OK;
		new_id_d  = '0;
		blk_d     = 1'b0;
		wake_d    = 1'b0;
		wake_id_d = '0;
		do_new    = 1'b0;
		do_free   = 1'b0;
		do_enq    = 1'b0;
		do_deq    = 1'b0;
		cnt_we    = 1'b0;
		cnt_d     = cnt_cur;
		case (opcode_s1)
			OP_NEW: begin
				st_d = alloc_status;
				if (alloc_status == ST_OK) begin
					do_new   = 1'b1;
					new_id_d = alloc_wide[3:0];
				end
			end
			OP_WAIT: begin
				if (!sid_ok) begin
					st_d = ST_BAD_ID;
				end else begin
					cnt_we = 1'b1;
					if (cnt_cur != CNT_MIN) begin
						cnt_d = cnt_cur - CNT_ONE;
					end
					if (cnt_d < 0) begin
						blk_d  = 1'b1;
						do_enq = 1'b1;
					end
				end
			end
			OP_SIGNAL: begin
				if (!sid_ok) begin
					st_d = ST_BAD_ID;
				end else begin
					cnt_we = 1'b1;
					if (cnt_cur != CNT_MAX) begin
						cnt_d = cnt_cur + CNT_ONE;
					end
					if (cnt_d <= 0 && ne_cur) begin
						wake_d    = 1'b1;
						wake_id_d = head_wide[4:0];
						do_deq    = 1'b1;
					end
				end
			end
			OP_FREE: begin
				if (!sid_ok) begin
					st_d = ST_BAD_ID;
				end else if (ne_cur) begin
					st_d = ST_WAITERS;
				end else begin
					do_free = 1'b1;
				end
			end
			default: begin
				st_d = ST_BAD_ID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			nonempty_q <= '0;
			for (int i = 0; i < NUM_SEMAPHORES; i++) begin
				count_q[i] <= '0;
			end
		end else if (advance) begin
			if (do_new) begin
				used_q[alloc_idx]     <= 1'b1;
				nonempty_q[alloc_idx] <= 1'b0;
				count_q[alloc_idx]    <= init_value_s1;
			end
			if (cnt_we) begin
				count_q[sid] <= cnt_d;
			end
			if (do_free) begin
				used_q[sid]  <= 1'b0;
				count_q[sid] <= '0;
			end
			if (do_enq && !ne_cur) begin
				nonempty_q[sid] <= 1'b1;
			end
			// The queue empties when the head being removed is also the tail.
			if (do_deq && head_cur == tail_cur) begin
				nonempty_q[sid] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && do_enq) begin
			tail_q[sid] <= req;
			if (ne_cur) begin
				next_q[tail_cur] <= req;
			end else begin
				head_q[sid] <= req;
			end
		end
		if (advance && do_deq && head_cur != tail_cur) begin
			head_q[sid] <= next_q[head_cur];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q     <= st_d;
			new_sem_id_q <= new_id_d;
			block_q      <= blk_d;
			wake_valid_q <= wake_d;
			wake_id_q    <= wake_id_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign new_sem_id      = new_sem_id_q;
	assign block_requester = block_q;
	assign wake_valid      = wake_valid_q;
	assign wake_id         = wake_id_q;

`ifndef SYNTHESIS
	// A queue can only hold waiters on a slot that is allocated.
	a_queue_on_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(nonempty_q & ~used_q) == 0)
		else $error("wait queue marked nonempty on an unused slot");

	// A request never both blocks and wakes.
	a_block_xor_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(block_q && wake_valid_q))
		else $error("result both blocks and wakes");

	// Error results carry no side effects.
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> !block_q && !wake_valid_q)
		else $error("failed request reports block or wake");

	// The input side stalls only behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a stalled result");

	// A processed request shows up as a result on the next cycle.
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed request produced no result");
`endif

endmodule
